// File: hw/rtl/ua_pkg.sv
// Shared operation codes and the pipeline control group for the 256-bit ALU.
package ua_pkg;

   // Operation codes carried on req_func.
   typedef enum logic [2:0] {
      FUNC_ADD = 3'd0,
      FUNC_SUB = 3'd1,
      FUNC_MUL = 3'd2,
      FUNC_DIV = 3'd3,
      FUNC_SHL = 3'd4,
      FUNC_SHR = 3'd5,
      FUNC_NOP = 3'd6,
      FUNC_RSV = 3'd7
   } func_type;

   // Control group that travels with each transaction along the cell chain.
   typedef struct packed {
      logic     valid;
      func_type op;
      logic     dz;
   } ctl_type;

   localparam int WORD_BITS = 64;
   localparam int WORDS     = 4;
   localparam int FULL_BITS = WORD_BITS * WORDS;

endpackage

// File: hw/rtl/ua_front.sv
// Entry stage: operand masking, add, subtract, shifts and divide-by-zero detection.
module ua_front #(
   parameter int N = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [2:0]                   func,
   input  logic [ua_pkg::FULL_BITS-1:0] a_full,
   input  logic [ua_pkg::FULL_BITS-1:0] b_full,
   input  logic [8:0]                   shift_amount,
   output ua_pkg::ctl_type              ctl_out,
   output logic [N-1:0]                 a_out,
   output logic [N-1:0]                 b_out
);
   import ua_pkg::*;

   logic [N-1:0] a_m, b_m, a_in, b_in;
   ctl_type      ctl_in, ctl_ff;
   logic [N-1:0] a_ff, b_ff;
   logic         big_shift;

   assign a_m       = a_full[N-1:0];
   assign b_m       = b_full[N-1:0];
   assign big_shift = 10'(shift_amount) >= 10'(N);

   // Simple operations finish here; multiply and divide go on to the cells.
   always_comb begin
      ctl_in.valid = in_valid;
      ctl_in.op    = FUNC_NOP;
      ctl_in.dz    = 1'b0;
      a_in         = '0;
      b_in         = b_m;
      case (func)
         FUNC_ADD: begin
            ctl_in.op = FUNC_ADD;
            a_in      = a_m + b_m;
         end
         FUNC_SUB: begin
            ctl_in.op = FUNC_SUB;
            a_in      = a_m - b_m;
         end
         FUNC_MUL: begin
            ctl_in.op = FUNC_MUL;
            a_in      = a_m;
         end
         FUNC_DIV: begin
            if (b_m == '0) begin
               ctl_in.dz = 1'b1;
            end else begin
               ctl_in.op = FUNC_DIV;
               a_in      = a_m;
            end
         end
         FUNC_SHL: begin
            ctl_in.op = FUNC_SHL;
            a_in      = big_shift ? '0 : (a_m << shift_amount);
         end
         FUNC_SHR: begin
            ctl_in.op = FUNC_SHR;
            a_in      = big_shift ? '0 : (a_m >> shift_amount);
         end
         default: begin
            ctl_in.op = FUNC_NOP;
         end
      endcase
   end

   // Stage register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff.valid <= ctl_in.valid;
      end
      if (en) begin
         ctl_ff.op <= ctl_in.op;
         ctl_ff.dz <= ctl_in.dz;
         a_ff      <= a_in;
         b_ff      <= b_in;
      end
   end

   assign ctl_out = ctl_ff;
   assign a_out   = a_ff;
   assign b_out   = b_ff;

endmodule

// File: hw/rtl/ua_cell.sv
// One cell of the chain: one multiplier bit (shift and add) or one quotient bit.
module ua_cell #(
   parameter int N = 256
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  ua_pkg::ctl_type ctl_in,
   input  logic [N-1:0]    a_in,
   input  logic [N-1:0]    b_in,
   input  logic [N-1:0]    acc_in,
   output ua_pkg::ctl_type ctl_out,
   output logic [N-1:0]    a_out,
   output logic [N-1:0]    b_out,
   output logic [N-1:0]    acc_out
);
   import ua_pkg::*;

   ctl_type      ctl_ff;
   logic [N-1:0] a_ff, b_ff, acc_ff;
   logic [N-1:0] a_nx, b_nx, acc_nx;
   logic [N:0]   wide;
   logic [N+1:0] diff;
   logic         ge;

   // Restoring divide step: the dividend's top bit enters the partial remainder.
   assign wide = {acc_in, a_in[N-1]};
   assign diff = {1'b0, wide} - {2'b00, b_in};
   assign ge   = ~diff[N+1];

   always_comb begin
      a_nx   = a_in;
      b_nx   = b_in;
      acc_nx = acc_in;
      case (ctl_in.op)
         FUNC_MUL: begin
            // Horner form: multiplier bits are taken from the top down.
            acc_nx = (acc_in << 1) + (b_in[N-1] ? a_in : '0);
            b_nx   = b_in << 1;
         end
         FUNC_DIV: begin
            acc_nx = ge ? diff[N-1:0] : wide[N-1:0];
            a_nx   = {a_in[N-2:0], ge};
         end
         default: begin
            a_nx = a_in;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (en) begin
         ctl_ff.valid <= ctl_in.valid;
      end
      if (en) begin
         ctl_ff.op <= ctl_in.op;
         ctl_ff.dz <= ctl_in.dz;
         a_ff      <= a_nx;
         b_ff      <= b_nx;
         acc_ff    <= acc_nx;
      end
   end

   assign ctl_out = ctl_ff;
   assign a_out   = a_ff;
   assign b_out   = b_ff;
   assign acc_out = acc_ff;

endmodule

// File: hw/rtl/uint256_arithmetic_unit.sv
// Top level of the pipelined unsigned ALU: entry stage followed by a chain of cells.
// One transaction is accepted per cycle while the chain is not stalled: the entry
// stage does add, subtract and shifts, then OPERAND_BITS identical cells each retire
// one multiplier bit or one quotient bit. The whole chain advances together; it stalls
// only while the final result register holds a transaction that has not been taken.
module uint256_arithmetic_unit #(
   parameter int OPERAND_BITS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [63:0] req_a_word0,
   input  logic [63:0] req_a_word1,
   input  logic [63:0] req_a_word2,
   input  logic [63:0] req_a_word3,
   input  logic [63:0] req_b_word0,
   input  logic [63:0] req_b_word1,
   input  logic [63:0] req_b_word2,
   input  logic [63:0] req_b_word3,
   input  logic [8:0]  req_shift_amount,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_result_word0,
   output logic [63:0] rsp_result_word1,
   output logic [63:0] rsp_result_word2,
   output logic [63:0] rsp_result_word3,
   output logic [63:0] rsp_remainder_word0,
   output logic [63:0] rsp_remainder_word1,
   output logic [63:0] rsp_remainder_word2,
   output logic [63:0] rsp_remainder_word3,
   output logic        rsp_divide_by_zero
);
   import ua_pkg::*;

   localparam int N = OPERAND_BITS;

   ctl_type      ctl_s [0:N];
   logic [N-1:0] a_s   [0:N];
   logic [N-1:0] b_s   [0:N];
   logic [N-1:0] acc_s [0:N];
   logic         en;
   logic [N-1:0] res, rem;
   logic [FULL_BITS-1:0] res_full, rem_full;

   // The chain moves when the last stage is empty or being taken.
   assign en        = ~ctl_s[N].valid | rsp_ready;
   assign req_ready = en;

   ua_front #(.N(N)) u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (en),
      .in_valid     (req_valid),
      .func         (req_func),
      .a_full       ({req_a_word3, req_a_word2, req_a_word1, req_a_word0}),
      .b_full       ({req_b_word3, req_b_word2, req_b_word1, req_b_word0}),
      .shift_amount (req_shift_amount),
      .ctl_out      (ctl_s[0]),
      .a_out        (a_s[0]),
      .b_out        (b_s[0])
   );
   assign acc_s[0] = '0;

   // Chain of cells.
   for (genvar i = 0; i < N; i++) begin : g_cell
      ua_cell #(.N(N)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .ctl_in  (ctl_s[i]),
         .a_in    (a_s[i]),
         .b_in    (b_s[i]),
         .acc_in  (acc_s[i]),
         .ctl_out (ctl_s[i+1]),
         .a_out   (a_s[i+1]),
         .b_out   (b_s[i+1]),
         .acc_out (acc_s[i+1])
      );
   end

   // Pick result and remainder by operation.
   always_comb begin
      res = a_s[N];
      rem = '0;
      case (ctl_s[N].op)
         FUNC_MUL: res = acc_s[N];
         FUNC_DIV: rem = acc_s[N];
         default:  res = a_s[N];
      endcase
   end

   assign res_full = FULL_BITS'(res);
   assign rem_full = FULL_BITS'(rem);

   assign rsp_valid           = ctl_s[N].valid;
   assign rsp_divide_by_zero  = ctl_s[N].dz;
   assign rsp_result_word0    = res_full[63:0];
   assign rsp_result_word1    = res_full[127:64];
   assign rsp_result_word2    = res_full[191:128];
   assign rsp_result_word3    = res_full[255:192];
   assign rsp_remainder_word0 = rem_full[63:0];
   assign rsp_remainder_word1 = rem_full[127:64];
   assign rsp_remainder_word2 = rem_full[191:128];
   assign rsp_remainder_word3 = rem_full[255:192];

endmodule
